// File: rtl/core/box_blur_3x3_edge_aware_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur core.
// Each macro expands to one labeled concurrent assertion, clocked on clock
// and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_CORE_DEFINES_SVH

// same-cycle implication
`define BB3_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BB3_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Types and constants shared by the 3x3 edge-aware box blur core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bb3_pkg;

   // default sizes and register reset values
   localparam int DEF_MAX_WIDTH     = 2048;
   localparam int DEF_MAX_HEIGHT    = 4096;
   localparam int DEF_IMAGE_WIDTH   = 640;
   localparam int DEF_IMAGE_HEIGHT  = 480;

   // register port
   localparam int IMAGE_WIDTH_W  = 12;
   localparam int IMAGE_HEIGHT_W = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   // pixel and arithmetic widths
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int SUM_W   = 12;
   localparam int COUNT_W = 4;
   localparam int TAPS    = 9;

   // input beat
   typedef struct packed {
      logic [CHAN_W-1:0] in_red;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_blue;
      logic              drain;
   } req_type;

   // result beat
   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic              last_pixel;
   } rsp_type;

   // per-item control from the position tracker to the window stage
   typedef struct packed {
      logic [PIX_W-1:0]   fresh;
      logic               emit;
      logic [TAPS-1:0]    mask;
      logic [COUNT_W-1:0] count;
      logic               last;
   } ctl_type;

   // masked neighborhood sums from the window stage to the divider
   typedef struct packed {
      logic [SUM_W-1:0]   sum_red;
      logic [SUM_W-1:0]   sum_green;
      logic [SUM_W-1:0]   sum_blue;
      logic [COUNT_W-1:0] count;
      logic               last;
   } sum_type;

endpackage

// File: rtl/core/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Generic single-write, single-read synchronous RAM with registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bb3_pos.sv
// ----------------------------------------------------------------------------
// bb3_pos
// Frame geometry registers and input/output position tracking. Decides per
// beat whether the item enters the pipeline, which line-store column it
// touches, and which neighbors of the pending result lie inside the image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_pos #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bb3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             accept,
   input  bb3_pkg::req_type                 req_data,
   output logic                             take,
   output logic [$clog2(MAX_WIDTH)-1:0]     rd_col,
   output bb3_pkg::ctl_type                 ctl
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CW1  = CW + 1;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int WH   = $clog2(MAX_HEIGHT + 1);
   localparam int RW   = $clog2(MAX_HEIGHT + 2);
   localparam int ORW  = $clog2(MAX_HEIGHT);
   localparam int ORW1 = ORW + 1;
   localparam int WIDTH_RESET  = (bb3_pkg::DEF_IMAGE_WIDTH > MAX_WIDTH) ?
                                 MAX_WIDTH : bb3_pkg::DEF_IMAGE_WIDTH;
   localparam int HEIGHT_RESET = (bb3_pkg::DEF_IMAGE_HEIGHT > MAX_HEIGHT) ?
                                 MAX_HEIGHT : bb3_pkg::DEF_IMAGE_HEIGHT;

   logic [WW-1:0]  width_ff, width_in;
   logic [WH-1:0]  height_ff, height_in;
   logic [CW-1:0]  in_col_ff, in_col_in;
   logic [RW-1:0]  in_row_ff, in_row_in;
   logic [CW-1:0]  out_col_ff, out_col_in;
   logic [ORW-1:0] out_row_ff, out_row_in;

   logic [31:0]    wval, hval, wsat, hsat;
   logic           cfg_hit;

   logic           frame_open;
   logic           ignore;
   logic           emit;
   logic           last;
   logic [CW1-1:0] col_inc;
   logic           row_wrap;
   logic [CW1-1:0] ocol_inc;
   logic [ORW1-1:0] orow_inc;
   logic [2:0]     rv;
   logic [2:0]     cv;
   logic [1:0]     nrows, ncols;
   logic [bb3_pkg::TAPS-1:0] mask;

   // saturate register writes into the legal frame size
   always_comb begin
      wval = 32'(csr_wdata[bb3_pkg::IMAGE_WIDTH_W-1:0]);
      hval = 32'(csr_wdata[bb3_pkg::IMAGE_HEIGHT_W-1:0]);
      wsat = (wval == 32'd0) ? 32'd1 : ((wval > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : wval);
      hsat = (hval == 32'd0) ? 32'd1 : ((hval > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : hval);
      width_in  = width_ff;
      height_in = height_ff;
      cfg_hit   = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            bb3_pkg::REG_IMAGE_WIDTH: begin
               width_in = wsat[WW-1:0];
               cfg_hit  = 1'b1;
            end
            bb3_pkg::REG_IMAGE_HEIGHT: begin
               height_in = hsat[WH-1:0];
               cfg_hit   = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   // classify the incoming beat
   assign frame_open = in_row_ff < RW'(height_ff);
   assign ignore     = frame_open && req_data.drain;
   assign take       = accept && !ignore;
   assign col_inc    = CW1'(in_col_ff) + CW1'(1);
   assign row_wrap   = col_inc >= CW1'(width_ff);
   assign emit       = (in_row_ff >= RW'(2)) ||
                       ((in_row_ff == RW'(1)) && (in_col_ff != '0));

   // neighbors of the pending result that lie inside the image
   assign ocol_inc = CW1'(out_col_ff) + CW1'(1);
   assign orow_inc = ORW1'(out_row_ff) + ORW1'(1);
   assign rv       = {orow_inc < ORW1'(height_ff), 1'b1, out_row_ff != '0};
   assign cv       = {ocol_inc < CW1'(width_ff), 1'b1, out_col_ff != '0};
   assign last     = (orow_inc == ORW1'(height_ff)) && (ocol_inc == CW1'(width_ff));
   assign nrows    = 2'd1 + 2'(rv[0]) + 2'(rv[2]);
   assign ncols    = 2'd1 + 2'(cv[0]) + 2'(cv[2]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mask[i*3+j] = rv[i] & cv[j];
         end
      end
   end

   // control bundle for the window stage
   always_comb begin
      ctl.fresh = frame_open ?
                  {req_data.in_red, req_data.in_green, req_data.in_blue} : '0;
      ctl.emit  = emit;
      ctl.mask  = mask;
      ctl.count = bb3_pkg::COUNT_W'(nrows) * bb3_pkg::COUNT_W'(ncols);
      ctl.last  = last;
   end

   assign rd_col = in_col_ff;

   // advance positions; a register write or the last result restarts the frame
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (cfg_hit) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (row_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = col_inc[CW-1:0];
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (ocol_inc >= CW1'(width_ff)) begin
               out_col_in = '0;
               out_row_in = orow_inc[ORW-1:0];
            end else begin
               out_col_in = ocol_inc[CW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WW'(WIDTH_RESET);
         height_ff  <= WH'(HEIGHT_RESET);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

// File: rtl/core/bb3_win.sv
// ----------------------------------------------------------------------------
// bb3_win
// Two line stores and the 3x3 window. Reads both stores for a taken beat,
// shifts the window and writes the lines back from stage 1 when it advances,
// forwarding the write-back to a read of the same column in that cycle.
// Registers the masked per-channel neighborhood sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_win #(
   parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          take,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
   input  bb3_pkg::ctl_type              ctl,
   output logic                          s2_vld,
   output bb3_pkg::sum_type              s2_sum
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int PIX_W = bb3_pkg::PIX_W;
   localparam int CH_W  = bb3_pkg::CHAN_W;
   localparam int ROW_W = CH_W + 2;

   logic                   s1_vld_ff;
   bb3_pkg::ctl_type       s1_ctl_ff;
   logic [CW-1:0]          s1_col_ff;
   logic                   fwd_ff;
   logic [PIX_W-1:0]       fwd_up_ff, fwd_mid_ff;
   logic [PIX_W-1:0]       win_ff [bb3_pkg::TAPS];
   logic [PIX_W-1:0]       win_in [bb3_pkg::TAPS];
   logic                   s2_vld_ff;
   bb3_pkg::sum_type       s2_sum_ff;

   logic [PIX_W-1:0]       up_q, mid_q, up_rd, mid_rd;
   logic                   wr_en;
   logic [ROW_W-1:0]       row_sum [3][3];
   logic [bb3_pkg::SUM_W-1:0] tot [3];

   assign wr_en = adv && s1_vld_ff;

   // upper line takes the old middle line; middle line takes the new pixel
   bb3_ram #(
      .DATA_W (PIX_W),
      .DEPTH  (MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (take),
      .rd_addr (rd_col),
      .rd_data (up_q)
   );

   bb3_ram #(
      .DATA_W (PIX_W),
      .DEPTH  (MAX_WIDTH)
   ) u_middle (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (s1_ctl_ff.fresh),
      .rd_en   (take),
      .rd_addr (rd_col),
      .rd_data (mid_q)
   );

   // forward the write-back that raced the read of the same column
   assign up_rd  = fwd_ff ? fwd_up_ff  : up_q;
   assign mid_rd = fwd_ff ? fwd_mid_ff : mid_q;

   // shift the window left and load the new right column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i*3]   = win_ff[i*3+1];
         win_in[i*3+1] = win_ff[i*3+2];
      end
      win_in[2] = up_rd;
      win_in[5] = mid_rd;
      win_in[8] = s1_ctl_ff.fresh;
   end

   // masked sums: three taps per row, then the three rows
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 3; c++) begin
            row_sum[i][c] = '0;
            for (int j = 0; j < 3; j++) begin
               if (s1_ctl_ff.mask[i*3+j]) begin
                  row_sum[i][c] = row_sum[i][c] + ROW_W'(win_in[i*3+j][c*CH_W +: CH_W]);
               end
            end
         end
      end
      for (int c = 0; c < 3; c++) begin
         tot[c] = bb3_pkg::SUM_W'(row_sum[0][c]) + bb3_pkg::SUM_W'(row_sum[1][c]) +
                  bb3_pkg::SUM_W'(row_sum[2][c]);
      end
   end

   // stage valids and forward flag
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= take;
         s2_vld_ff <= s1_vld_ff && s1_ctl_ff.emit;
         fwd_ff    <= take && s1_vld_ff && (rd_col == s1_col_ff);
      end
   end

   // stage payloads; hold everything while the output is stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         if (take) begin
            s1_ctl_ff <= ctl;
            s1_col_ff <= rd_col;
         end
         fwd_up_ff  <= mid_rd;
         fwd_mid_ff <= s1_ctl_ff.fresh;
         if (s1_vld_ff) begin
            win_ff              <= win_in;
            s2_sum_ff.sum_red   <= tot[2];
            s2_sum_ff.sum_green <= tot[1];
            s2_sum_ff.sum_blue  <= tot[0];
            s2_sum_ff.count     <= s1_ctl_ff.count;
            s2_sum_ff.last      <= s1_ctl_ff.last;
         end
      end
   end

   assign s2_vld = s2_vld_ff;
   assign s2_sum = s2_sum_ff;

endmodule

// File: rtl/core/bb3_div.sv
// ----------------------------------------------------------------------------
// bb3_div
// Rounded mean per channel: (2*sum+count)/(2*count), computed as a multiply
// by a scaled reciprocal of 2*count, which is exact over the sum range.
// Holds the result beat in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             s2_vld,
   input  bb3_pkg::sum_type s2_sum,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output bb3_pkg::rsp_type rsp_data,
   output logic             adv
);

   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 17;
   localparam int X_W         = bb3_pkg::SUM_W + 1;
   localparam int PROD_W      = X_W + RECIP_W;

   logic                rsp_valid_ff;
   bb3_pkg::rsp_type    rsp_data_ff;
   logic [RECIP_W-1:0]  recip_m;
   logic [X_W-1:0]      x [3];
   logic [PROD_W-1:0]   prod [3];
   logic [bb3_pkg::SUM_W-1:0] sums [3];

   // ceil(2^17 / (2*n)) for the neighbor counts that can occur
   function automatic logic [RECIP_W-1:0] recip(input logic [bb3_pkg::COUNT_W-1:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         4'd2:    m = 17'd32768;
         4'd3:    m = 17'd21846;
         4'd4:    m = 17'd16384;
         4'd6:    m = 17'd10923;
         4'd9:    m = 17'd7282;
         default: m = 17'd65536;
      endcase
      return m;
   endfunction

   assign adv     = !rsp_valid_ff || rsp_ready;
   assign recip_m = recip(s2_sum.count);
   assign sums[2] = s2_sum.sum_red;
   assign sums[1] = s2_sum.sum_green;
   assign sums[0] = s2_sum.sum_blue;

   // scale and multiply each channel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         x[c]    = {sums[c], 1'b0} + X_W'(s2_sum.count);
         prod[c] = PROD_W'(x[c]) * PROD_W'(recip_m);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_vld;
      end
   end

   // load the result beat
   always_ff @(posedge clock) begin
      if (adv && s2_vld) begin
         rsp_data_ff.out_red    <= prod[2][RECIP_SHIFT +: bb3_pkg::CHAN_W];
         rsp_data_ff.out_green  <= prod[1][RECIP_SHIFT +: bb3_pkg::CHAN_W];
         rsp_data_ff.out_blue   <= prod[0][RECIP_SHIFT +: bb3_pkg::CHAN_W];
         rsp_data_ff.last_pixel <= s2_sum.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/box_blur_3x3_edge_aware_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core: RGB 3x3 edge-aware mean filter, raster order
// Results trail their input by width+1 items. Throughput: 1 item per cycle
// unless the output stalls, paced by one read and one write per cycle on each
// line store, with same-column write-back forwarded. Reset: synchronous;
// clears positions and valids, loads 640x480; line stores are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_aware_core_defines.svh"

module box_blur_3x3_edge_aware_core #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bb3_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bb3_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [bb3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                          accept;
   logic                          take;
   logic [$clog2(MAX_WIDTH)-1:0]  rd_col;
   bb3_pkg::ctl_type              ctl;
   logic                          s2_vld;
   bb3_pkg::sum_type              s2_sum;
   logic                          adv;

   // whole pipeline moves when the output register can take a beat
   assign req_ready = adv;
   assign accept    = req_valid && req_ready;

   bb3_pos #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pos (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .take      (take),
      .rd_col    (rd_col),
      .ctl       (ctl)
   );

   bb3_win #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_win (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .take   (take),
      .rd_col (rd_col),
      .ctl    (ctl),
      .s2_vld (s2_vld),
      .s2_sum (s2_sum)
   );

   bb3_div u_div (
      .clock     (clock),
      .reset     (reset),
      .s2_vld    (s2_vld),
      .s2_sum    (s2_sum),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .adv       (adv)
   );

   // neighbor count agrees with the in-image mask
   `BB3_ASSERT_IMP(a_count_mask, take && ctl.emit, $countones(ctl.mask) == 32'(ctl.count), "count does not match mask")
   // the center pixel is always part of the mean
   `BB3_ASSERT_IMP(a_center_in, take && ctl.emit, ctl.mask[4], "center tap masked")
   // sums hold while the output is stalled
   `BB3_ASSERT_NXT(a_sum_hold, s2_vld && !adv, s2_vld && $stable(s2_sum), "sum stage lost under stall")

endmodule
